FILE: rtl/bssi_pkg.sv
// Package for the bucketed sorted set intersection unit.
// Request codes, state type, cell control type and default sizes; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bssi_pkg;
   localparam int CAPACITY_DEF      = 256;
   localparam int MAX_BUCKETS_DEF   = 64;
   localparam int BUCKET_TARGET_DEF = 16;
   localparam int VALUE_W           = 32;
   localparam int COUNT_W           = 9;
   localparam int BITS_W            = 6;

   typedef enum logic [1:0] {
      REQ_CLEAR  = 2'd0,
      REQ_INSERT = 2'd1,
      REQ_BUILD  = 2'd2,
      REQ_PROBE  = 2'd3
   } req_code_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS_SCAN,
      ST_INS_SHIFT,
      ST_BLD_CALC,
      ST_BLD_WALK,
      ST_PRB_LOOK,
      ST_PRB_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic shift_en;
      logic load_en;
   } cell_ctrl_type;
endpackage
`default_nettype wire

FILE: rtl/bucketed_sorted_set_intersection_unit.sv
// Top level of the bucketed sorted set intersection unit; one request at a time, busy while working.
// Clear goes straight to the rsp_valid strobe; insert scans the stored values below the new value,
// then shifts the store unless it is a duplicate or the store is full; build sizes the buckets, then
// walks entries and buckets; probe reads the bucket offsets, then scans the bucket's entries. The next
// beat can be taken in the cycle after the strobe, which cannot stall. Synchronous active-high reset
// empties the set; offsets read as zero until the first build, store cells hold no reset value.
`timescale 1ns / 1ps
`default_nettype none
module bucketed_sorted_set_intersection_unit
   import bssi_pkg::*;
#(
   parameter int CAPACITY      = CAPACITY_DEF,
   parameter int MAX_BUCKETS   = MAX_BUCKETS_DEF,
   parameter int BUCKET_TARGET = BUCKET_TARGET_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_type,
   input  wire logic [VALUE_W-1:0] req_value,
   output logic                    rsp_valid,
   output logic [VALUE_W-1:0]      rsp_value_echo,
   output logic                    rsp_found,
   output logic [$clog2(CAPACITY + 1)-1:0] rsp_stored_count,
   output logic                    rsp_overflow
);
   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int MAXBITS = $clog2(MAX_BUCKETS + 1) - 1;
   localparam int NB_MAX = 1 << MAXBITS;
   localparam int BK_W   = MAXBITS + 1;
   localparam int TGT_W  = $clog2(BUCKET_TARGET + 1);
   localparam int P_W    = VALUE_W + TGT_W;
   localparam int K_W    = 8;

   state_type state_ff, state_in;
   req_code_type req_ff, req_in;
   logic [VALUE_W-1:0] val_ff, val_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [VALUE_W-1:0] largest_ff, largest_in;
   logic [BITS_W-1:0] bbits_ff, bbits_in;
   logic [BITS_W-1:0] shift_ff, shift_in;
   logic [BK_W-1:0] pbucket_ff, pbucket_in;
   logic pvalid_ff, pvalid_in;
   logic [CNT_W-1:0] ppos_ff, ppos_in;
   logic ended_ff, ended_in;
   logic idx_ff, idx_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic [BK_W-1:0] bk_ff, bk_in;
   logic signed [K_W-1:0] k_ff, k_in;
   logic kdir_ff, kdir_in;
   logic found_ff, found_in;
   logic ovf_ff, ovf_in;
   logic [CNT_W-1:0] end_ff, end_in;
   logic [CNT_W-1:0] offs [NB_MAX+1];
   logic [CNT_W-1:0] od0_ff, od1_ff;

   logic ins_en;
   logic [IDX_W-1:0] rd_pos;
   logic [VALUE_W-1:0] rd_val;
   logic off_we;
   logic [BK_W-1:0] off_wa;
   logic [CNT_W-1:0] off_wd;
   logic [VALUE_W-1:0] vb_req;
   logic [BK_W-1:0] oa0, oa1;
   logic [CNT_W-1:0] o0, o1;
   logic [P_W-1:0] p_val;
   logic [P_W+K_W-1:0] len_sh, p_sh;
   logic [BITS_W-1:0] rb;
   logic signed [K_W+1:0] bits_s;
   logic [VALUE_W-1:0] vb;
   logic [BK_W:0] nb;
   logic [VALUE_W-1:0] cur_bucket;

   bssi_chain #(.CAPACITY(CAPACITY)) u_chain (
      .clock        (clock),
      .insert_en    (ins_en),
      .insert_pos   (pos_ff[IDX_W-1:0]),
      .insert_value (val_ff),
      .read_pos     (rd_pos),
      .read_value   (rd_val)
   );

   assign vb_req = req_value >> shift_ff;
   assign oa0    = vb_req[BK_W-1:0];
   assign oa1    = vb_req[BK_W-1:0] + BK_W'(1);

   always_ff @(posedge clock) begin
      if (off_we) begin
         offs[off_wa] <= off_wd;
      end
      od0_ff <= offs[oa0];
      od1_ff <= offs[oa1];
   end

   assign o0 = idx_ff ? od0_ff : '0;
   assign o1 = idx_ff ? od1_ff : '0;

   always_comb begin
      rb = '0;
      for (int i = 0; i < VALUE_W; i++) begin
         if (largest_ff[i]) rb = BITS_W'(i + 1);
      end
   end

   assign p_val  = P_W'(largest_ff) * P_W'(BUCKET_TARGET);
   assign len_sh = (P_W+K_W)'(count_ff) << k_ff[5:0];
   assign p_sh   = (P_W+K_W)'(p_val) << k_ff[5:0];
   assign nb     = (BK_W+1)'(1) << bbits_ff;
   assign vb     = val_ff >> shift_ff;
   assign cur_bucket = rd_val >> shift_ff;
   assign ins_en = (state_ff == ST_INS_SHIFT);
   assign rd_pos = (state_in == ST_PRB_SCAN) ? ppos_in[IDX_W-1:0] : pos_in[IDX_W-1:0];

   always_comb begin
      bits_s = (K_W+2)'(signed'({1'b0, rb}));
      if (kdir_ff) bits_s = bits_s + (K_W+2)'(k_ff);
      else bits_s = bits_s - (K_W+2)'(k_ff);
      if (bits_s > (K_W+2)'(signed'({1'b0, rb}))) bits_s = (K_W+2)'(signed'({1'b0, rb}));
      if (bits_s > (K_W+2)'(MAXBITS)) bits_s = (K_W+2)'(MAXBITS);
      if (bits_s < (K_W+2)'(1)) bits_s = (K_W+2)'(1);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req_code_type'(req_type))
                  REQ_CLEAR:  state_in = ST_DONE;
                  REQ_INSERT: state_in = ST_INS_SCAN;
                  REQ_BUILD:  state_in = ST_BLD_CALC;
                  REQ_PROBE:  state_in = ST_PRB_LOOK;
                  default:    state_in = ST_DONE;
               endcase
            end
         end
         ST_INS_SCAN: begin
            if (pos_ff >= count_ff || rd_val >= val_ff) begin
               if ((pos_ff < count_ff && rd_val == val_ff) || count_ff >= CNT_W'(CAPACITY)) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_INS_SHIFT;
               end
            end
         end
         ST_INS_SHIFT: state_in = ST_DONE;
         ST_BLD_CALC: begin
            if (count_ff == '0 || largest_ff == '0) begin
               state_in = ST_BLD_WALK;
            end else if (kdir_ff) begin
               if (k_ff >= K_W'(20) || (p_val << (k_ff[5:0] + 6'd1)) > (P_W+K_W)'(count_ff)) begin
                  state_in = ST_BLD_WALK;
               end
            end else if (k_ff >= K_W'(60) || len_sh >= (P_W+K_W)'(p_val)) begin
               state_in = ST_BLD_WALK;
            end
         end
         ST_BLD_WALK: begin
            if (bk_ff == nb[BK_W-1:0] + BK_W'(0) && bk_ff != '0 && nb[BK_W-1:0] == bk_ff) begin
               state_in = ST_DONE;
            end else if ({1'b0, bk_ff} == nb) begin
               state_in = ST_DONE;
            end
         end
         ST_PRB_LOOK: begin
            state_in = ST_PRB_SCAN;
            if (ended_ff) state_in = ST_DONE;
            else if (!pvalid_ff || vb != VALUE_W'(pbucket_ff)) begin
               if (vb >= VALUE_W'(nb)) state_in = ST_DONE;
               else if (o1 <= o0) state_in = ST_DONE;
            end
         end
         ST_PRB_SCAN: begin
            if (ppos_ff >= CNT_W'(CAPACITY)) state_in = ST_DONE;
            else if (!(ppos_ff + CNT_W'(1) < end_ff && ppos_ff + CNT_W'(1) < CNT_W'(CAPACITY)
                       && rd_val < val_ff)) state_in = ST_DONE;
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_in = req_ff; val_in = val_ff; count_in = count_ff; largest_in = largest_ff;
      bbits_in = bbits_ff; shift_in = shift_ff; pbucket_in = pbucket_ff;
      pvalid_in = pvalid_ff; ppos_in = ppos_ff; ended_in = ended_ff; pos_in = pos_ff;
      bk_in = bk_ff; k_in = k_ff; kdir_in = kdir_ff; found_in = found_ff; ovf_in = ovf_ff;
      end_in = end_ff; idx_in = idx_ff; off_we = 1'b0; off_wa = bk_ff; off_wd = pos_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in = req_code_type'(req_type); val_in = req_value;
               found_in = 1'b0; ovf_in = 1'b0; pos_in = '0; bk_in = '0;
               kdir_in = (CNT_W+P_W)'(count_ff) >= (CNT_W+P_W)'(p_val);
               k_in = kdir_in ? '0 : K_W'(1);
               if (req_code_type'(req_type) == REQ_CLEAR) begin
                  count_in = '0; largest_in = '0; bbits_in = BITS_W'(1); shift_in = '0;
                  pbucket_in = '1; pvalid_in = 1'b0; ppos_in = '0; ended_in = 1'b0;
                  idx_in = 1'b0;
               end
            end
         end
         ST_INS_SCAN: begin
            if (pos_ff >= count_ff || rd_val >= val_ff) begin
               if (!(pos_ff < count_ff && rd_val == val_ff) && count_ff >= CNT_W'(CAPACITY)) begin
                  ovf_in = 1'b1;
               end
            end else begin
               pos_in = pos_ff + CNT_W'(1);
            end
         end
         ST_INS_SHIFT: begin
            count_in = count_ff + CNT_W'(1);
            if (val_ff > largest_ff) largest_in = val_ff;
         end
         ST_BLD_CALC: begin
            if (count_ff == '0 || largest_ff == '0) begin
               bbits_in = BITS_W'(1); shift_in = '0;
            end else if (kdir_ff) begin
               if (k_ff >= K_W'(20) || (p_val << (k_ff[5:0] + 6'd1)) > (P_W+K_W)'(count_ff)) begin
                  k_in = -k_ff;
                  bbits_in = BITS_W'(bits_s); shift_in = rb - BITS_W'(bits_s);
               end else k_in = k_ff + K_W'(1);
            end else if (k_ff >= K_W'(60) || len_sh >= (P_W+K_W)'(p_val)) begin
               bbits_in = BITS_W'(bits_s); shift_in = rb - BITS_W'(bits_s);
            end else k_in = k_ff + K_W'(1);
            pos_in = '0; bk_in = '0; idx_in = 1'b1;
            off_we = 1'b1; off_wa = '0; off_wd = '0;
         end
         ST_BLD_WALK: begin
            if ({1'b0, bk_ff} == nb) begin
               off_we = 1'b1; off_wd = count_ff;
               pbucket_in = '1; pvalid_in = 1'b0; ppos_in = '0; ended_in = 1'b0;
            end else if (pos_ff < count_ff && pos_ff < CNT_W'(CAPACITY)
                         && cur_bucket == VALUE_W'(bk_ff)) begin
               pos_in = pos_ff + CNT_W'(1);
            end else begin
               off_we = 1'b1; off_wa = bk_ff + BK_W'(1); bk_in = bk_ff + BK_W'(1);
            end
         end
         ST_PRB_LOOK: begin
            if (!ended_ff && (!pvalid_ff || vb != VALUE_W'(pbucket_ff))) begin
               if (vb >= VALUE_W'(nb)) ended_in = 1'b1;
               else if (o1 <= o0) begin
                  pvalid_in = 1'b0; pbucket_in = '1;
               end else begin
                  pbucket_in = vb[BK_W-1:0]; pvalid_in = 1'b1;
                  ppos_in = o0;
                  end_in = o1;
               end
            end
         end
         ST_PRB_SCAN: begin
            if (ppos_ff < CNT_W'(CAPACITY)) begin
               if (ppos_ff + CNT_W'(1) < end_ff && ppos_ff + CNT_W'(1) < CNT_W'(CAPACITY)
                   && rd_val < val_ff) ppos_in = ppos_ff + CNT_W'(1);
               else found_in = (rd_val == val_ff);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; count_ff <= '0; largest_ff <= '0;
         bbits_ff <= BITS_W'(1); shift_ff <= '0; pbucket_ff <= '1; pvalid_ff <= 1'b0;
         ppos_ff <= '0; ended_ff <= 1'b0; idx_ff <= 1'b0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; largest_ff <= largest_in;
         bbits_ff <= bbits_in; shift_ff <= shift_in; pbucket_ff <= pbucket_in;
         pvalid_ff <= pvalid_in; ppos_ff <= ppos_in; ended_ff <= ended_in; idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in; val_ff <= val_in; pos_ff <= pos_in; bk_ff <= bk_in;
      k_ff <= k_in; kdir_ff <= kdir_in; found_ff <= found_in; ovf_ff <= ovf_in;
      end_ff <= end_in;
   end

   always_comb begin
      busy             = (state_ff != ST_IDLE);
      rsp_valid        = (state_ff == ST_DONE);
      rsp_value_echo   = val_ff;
      rsp_found        = found_ff && (req_ff == REQ_PROBE);
      rsp_stored_count = count_ff;
      rsp_overflow     = ovf_ff && (req_ff == REQ_INSERT);
   end
endmodule
`default_nettype wire

FILE: rtl/bssi_cell.sv
// One storage cell of the sorted value chain.
// Depends on bssi_pkg; holds one value, loads the insert value when selected, else takes the value below on a shift.
`timescale 1ns / 1ps
`default_nettype none
module bssi_cell
   import bssi_pkg::*;
(
   input  wire logic               clock,
   input  wire bssi_pkg::cell_ctrl_type ctrl,
   input  wire logic               sel_load,
   input  wire logic [VALUE_W-1:0] left_value,
   input  wire logic [VALUE_W-1:0] load_value,
   output logic      [VALUE_W-1:0] cell_value
);
   logic [VALUE_W-1:0] value_ff;
   logic [VALUE_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      if (ctrl.load_en && sel_load) begin
         value_in = load_value;
      end else if (ctrl.shift_en) begin
         value_in = left_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign cell_value = value_ff;
endmodule
`default_nettype wire

FILE: rtl/bssi_chain.sv
// Row of storage cells forming the sorted store.
// Depends on bssi_pkg and bssi_cell; cells above the insert point shift up, the cell at it loads the new value.
`timescale 1ns / 1ps
`default_nettype none
module bssi_chain
   import bssi_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   localparam int IDX_W = $clog2(CAPACITY)
) (
   input  wire logic               clock,
   input  wire logic               insert_en,
   input  wire logic [IDX_W-1:0]   insert_pos,
   input  wire logic [VALUE_W-1:0] insert_value,
   input  wire logic [IDX_W-1:0]   read_pos,
   output logic      [VALUE_W-1:0] read_value
);
   logic [VALUE_W-1:0] cells [CAPACITY];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      cell_ctrl_type ctrl;
      logic [VALUE_W-1:0] left;
      assign ctrl = {insert_en && (IDX_W'(i) > insert_pos), insert_en};
      if (i == 0) begin : g_first
         assign left = cells[0];
      end else begin : g_rest
         assign left = cells[i-1];
      end
      bssi_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .sel_load   (IDX_W'(i) == insert_pos),
         .left_value (left),
         .load_value (insert_value),
         .cell_value (cells[i])
      );
   end

   always_ff @(posedge clock) begin
      read_value <= cells[read_pos];
   end
endmodule
`default_nettype wire

FILE: rtl/bssi_checker.sv
// Port-level checker for the bucketed sorted set intersection unit.
// Depends on bssi_pkg; bound to the top level below.
`timescale 1ns / 1ps
`default_nettype none
module bssi_checker
   import bssi_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   localparam int CNT_W = $clog2(CAPACITY + 1)
) (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire logic             rsp_valid,
   input wire logic             rsp_found,
   input wire logic             rsp_overflow,
   input wire logic [CNT_W-1:0] rsp_stored_count
);
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accepted beat did not raise busy");
   a_strobe_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than one cycle");
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_found && rsp_overflow)) else $error("found and overflow together");
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_stored_count <= CNT_W'(CAPACITY)) else $error("count too large");
endmodule

bind bucketed_sorted_set_intersection_unit bssi_checker #(.CAPACITY(CAPACITY)) u_bssi_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy), .rsp_valid(rsp_valid),
   .rsp_found(rsp_found), .rsp_overflow(rsp_overflow), .rsp_stored_count(rsp_stored_count)
);
`default_nettype wire

FILE: tb/tb_top.sv
// Testbench for bucketed_sorted_set_intersection_unit: directed and random request beats,
// a scoreboard class that predicts every response beat. Depends on rtl/bssi_pkg.sv and the top level.
`timescale 1ns / 1ps
module tb_top;
   import bssi_pkg::*;

   typedef struct {
      logic [31:0] value_echo;
      logic        found;
      logic [8:0]  stored_count;
      logic        overflow;
   } set_rsp_t;

   class set_scoreboard;
      bit [31:0]   vals[256];
      int          cnt;
      bit [31:0]   largest;
      int          offs[65];
      int          bits;
      int          shift;
      bit [31:0]   cur_bucket;
      bit          cur_valid;
      int          cur_pos;
      bit          ended;
      set_rsp_t    pending[$];

      function new();
         wipe();
      endfunction

      function void wipe();
         foreach (vals[i]) vals[i] = 0;
         foreach (offs[i]) offs[i] = 0;
         cnt = 0;
         largest = 0;
         bits = 1;
         shift = 0;
         rewind();
      endfunction

      function void rewind();
         cur_bucket = 32'h7f;
         cur_valid = 0;
         cur_pos = 0;
         ended = 0;
      endfunction

      function bit add_value(bit [31:0] v);
         int p;
         p = 0;
         while (p < cnt && vals[p] < v) p++;
         if (p < cnt && vals[p] == v) return 0;
         if (cnt >= 256) return 1;
         for (int i = cnt; i > p; i--) vals[i] = vals[i-1];
         vals[p] = v;
         cnt++;
         if (v > largest) largest = v;
         return 0;
      endfunction

      function void index_buckets();
         longint unsigned p, len;
         int rb, k, m, nb, cur;
         bit [31:0] t;
         if (cnt == 0 || largest == 0) begin
            bits = 1;
            shift = 0;
         end else begin
            p = longint'(largest) * 16;
            len = cnt;
            rb = 0;
            t = largest;
            while (t != 0) begin
               rb++;
               t = t >> 1;
            end
            if (len >= p) begin
               m = 0;
               while (m < 20 && (p << (m + 1)) <= len) m++;
               k = -m;
            end else begin
               k = 1;
               while (k < 60 && (len << k) < p) k++;
            end
            bits = rb - k;
            if (bits > rb) bits = rb;
            if (bits > 6) bits = 6;
            if (bits < 1) bits = 1;
            shift = rb - bits;
         end
         nb = 1 << bits;
         cur = 0;
         for (int i = 0; i < nb; i++) begin
            offs[i] = cur;
            while (cur < cnt && (vals[cur] >> shift) == i) cur++;
         end
         offs[nb] = cnt;
         rewind();
      endfunction

      function bit lookup(bit [31:0] v);
         bit [31:0] b;
         int stop;
         b = v >> shift;
         if (ended) return 0;
         if (!cur_valid || b != cur_bucket) begin
            if (b >= (1 << bits)) begin
               ended = 1;
               return 0;
            end
            if (offs[b+1] <= offs[b]) begin
               cur_valid = 0;
               cur_bucket = 32'h7f;
               return 0;
            end
            cur_bucket = b;
            cur_valid = 1;
            cur_pos = offs[b];
         end
         stop = offs[cur_bucket+1];
         if (cur_pos >= 256) return 0;
         while (cur_pos + 1 < stop && vals[cur_pos] < v) cur_pos++;
         return vals[cur_pos] == v;
      endfunction

      function void note_request(req_code_type t, bit [31:0] v);
         set_rsp_t r;
         r.value_echo = v;
         r.found = 0;
         r.overflow = 0;
         case (t)
            REQ_CLEAR: wipe();
            REQ_INSERT: r.overflow = add_value(v);
            REQ_BUILD: index_buckets();
            default: r.found = lookup(v);
         endcase
         r.stored_count = cnt[8:0];
         pending.push_back(r);
      endfunction

      // returns 0 when no beat was waiting
      function bit check_response(set_rsp_t got, output set_rsp_t exp, output bit ok);
         ok = 0;
         if (pending.size() == 0) return 0;
         exp = pending.pop_front();
         ok = (got.value_echo === exp.value_echo) && (got.found === exp.found) &&
              (got.stored_count === exp.stored_count) && (got.overflow === exp.overflow);
         return 1;
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [1:0]  req_type = REQ_CLEAR;
   logic [31:0] req_value = 0;
   logic        rsp_valid;
   logic [31:0] rsp_value_echo;
   logic        rsp_found;
   logic [8:0]  rsp_stored_count;
   logic        rsp_overflow;

   set_scoreboard sb = new();
   int errors = 0;
   int n_items = 0;
   int n_rsp = 0;
   int n_found = 0;
   int n_ovf = 0;
   int idle_pct = 0;
   bit [31:0] probes[$];

   bucketed_sorted_set_intersection_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_value_echo(rsp_value_echo), .rsp_found(rsp_found),
      .rsp_stored_count(rsp_stored_count), .rsp_overflow(rsp_overflow)
   );

   always #10 clock = ~clock;

   task automatic report(string msg);
      $display("mismatch @%0t: %s", $time, msg);
      errors++;
   endtask

   always @(posedge clock) begin
      if (!reset && start && !busy) sb.note_request(req_code_type'(req_type), req_value);
   end

   always @(posedge clock) begin
      set_rsp_t got, exp;
      bit ok;
      if (!reset && rsp_valid) begin
         got.value_echo = rsp_value_echo;
         got.found = rsp_found;
         got.stored_count = rsp_stored_count;
         got.overflow = rsp_overflow;
         n_rsp++;
         if (rsp_found) n_found++;
         if (rsp_overflow) n_ovf++;
         if (!sb.check_response(got, exp, ok))
            report($sformatf("unexpected beat value=%h", got.value_echo));
         else if (!ok)
            report($sformatf("value %h/%h found %b/%b count %0d/%0d ovf %b/%b",
               got.value_echo, exp.value_echo, got.found, exp.found,
               got.stored_count, exp.stored_count, got.overflow, exp.overflow));
      end
   end

   task automatic send(req_code_type t, bit [31:0] v);
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         start <= 0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      start <= 1;
      req_type <= t;
      req_value <= v;
      do @(posedge clock); while (busy);
      n_items++;
   endtask

   task automatic probe_run(int m, bit [31:0] hi);
      probes.delete();
      for (int i = 0; i < m; i++) begin
         if (sb.cnt > 0 && $urandom_range(0, 1)) probes.push_back(sb.vals[$urandom_range(0, sb.cnt-1)]);
         else probes.push_back($urandom_range(0, hi));
      end
      if ($urandom_range(0, 9) != 0) probes.sort();
      foreach (probes[i]) send(REQ_PROBE, probes[i]);
   endtask

   initial begin
      bit [31:0] hi;
      bit filled;
      int sel;
      filled = 0;
      repeat (9) @(posedge clock);
      reset <= 0;
      send(REQ_BUILD, 32'h0);
      send(REQ_PROBE, 32'h0);
      send(REQ_INSERT, 32'h0);
      send(REQ_INSERT, 32'hffff_ffff);
      send(REQ_INSERT, 32'h5);
      send(REQ_INSERT, 32'h5);
      send(REQ_BUILD, 32'hdead_beef);
      send(REQ_PROBE, 32'h0);
      send(REQ_PROBE, 32'h5);
      send(REQ_PROBE, 32'h6);
      send(REQ_PROBE, 32'hffff_ffff);
      send(REQ_PROBE, 32'h3);
      send(REQ_CLEAR, 32'h1234_5678);
      send(REQ_INSERT, 32'h0);
      send(REQ_BUILD, 32'h0);
      send(REQ_PROBE, 32'h0);
      send(REQ_PROBE, 32'h1);
      send(REQ_PROBE, 32'h7);
      send(REQ_PROBE, 32'h0);
      send(REQ_INSERT, 32'h64);
      send(REQ_PROBE, 32'h64);
      while (n_items < 700) begin
         idle_pct = (n_items < 200) ? 0 : (n_items < 400) ? 63 : (n_items < 550) ? 0 : 19;
         sel = $urandom_range(0, 3);
         hi = (sel == 0) ? 32'hff : (sel == 1) ? 32'hfff : (sel == 2) ? 32'hf_ffff : 32'hffff_ffff;
         if (!filled && n_items > 250) begin
            filled = 1;
            send(REQ_CLEAR, $urandom);
            while (sb.cnt < 256) send(REQ_INSERT, $urandom);
            send(REQ_INSERT, $urandom);
            send(REQ_INSERT, sb.vals[10]);
            send(REQ_BUILD, $urandom);
            probe_run(30, 32'hffff_ffff);
         end else if ($urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(1, 6))
               send(req_code_type'($urandom_range(0, 3)), $urandom_range(0, hi));
         end else begin
            if ($urandom_range(0, 1)) send(REQ_CLEAR, $urandom);
            repeat ($urandom_range(0, 40)) send(REQ_INSERT, $urandom_range(0, hi));
            if ($urandom_range(0, 7) != 0) send(REQ_BUILD, $urandom);
            probe_run($urandom_range(1, 30), hi);
         end
      end
      start <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("covered %0d request beats, %0d response beats (%0d found, %0d overflow)",
         n_items, n_rsp, n_found, n_ovf);
      $display("full store, duplicates, stale index, ended probing and idle phases exercised");
      if (errors == 0) begin
         $display("[bucketed_sorted_set_intersection_unit] OK");
      end else begin
         $display("[bucketed_sorted_set_intersection_unit] ERROR");
      end
      $finish;
   end

   initial begin
      #50ms;
      $display("[bucketed_sorted_set_intersection_unit] ERROR");
      $finish;
   end
endmodule

FILE: filelist.f
rtl/bssi_pkg.sv
rtl/bssi_cell.sv
rtl/bssi_chain.sv
rtl/bucketed_sorted_set_intersection_unit.sv
rtl/bssi_checker.sv
tb/tb_top.sv
